// ===== src/pcs_pkg.sv =====
package pcs_pkg;

  // Default build-time settings.
  localparam int DEF_COORD_FRAC_BITS = 16;
  localparam int DEF_SCREEN_BITS     = 13;

  // Field widths fixed by the command format.
  localparam int COORD_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int SCALE_W   = 16;
  localparam int OFFS_W    = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 2'd2;

  // Reset values of the registers.
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd4096;

  // Command codes.
  localparam logic FUNC_MOVE = 1'b0;
  localparam logic FUNC_LINE = 1'b1;

endpackage

// ===== src/pcs_if.sv =====
interface pcs_in_if import pcs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  modport source (output valid, func, pos_x, pos_y, input ready);
  modport sink   (input valid, func, pos_x, pos_y, output ready);
endinterface

interface pcs_out_if import pcs_pkg::*; #(parameter int SB = DEF_SCREEN_BITS) ();
  logic                 valid;
  logic                 ready;
  logic                 visible;
  logic signed [SB-1:0] x_start;
  logic signed [SB-1:0] y_start;
  logic signed [SB-1:0] x_end;
  logic signed [SB-1:0] y_end;
  modport source (output valid, visible, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, visible, x_start, y_start, x_end, y_end, output ready);
endinterface

interface pcs_cfg_if import pcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/polyline_clip_and_scale_top.sv =====
// Polyline clip and scale.
// in_ch carries move and line commands with a Q.F point. A move only stores
// the point. A line clips the segment from the stored point to the new one
// against the square view and gives one item on out_ch: a visible flag and
// two screen points (all zero when the segment is not visible).
// cfg_ch writes scale_factor, quad_left and quad_top; it is always ready and
// should only be used while no line is in progress.
// Timing: a move is taken in idle and needs no further step. A line is
// accepted, then passes a check step, a crossing step for each boundary
// tried and, for each boundary whose crossing needs the division, the
// shared restoring divider, the steps through the shared multiplier and a
// check, then screen mapping over the same multiplier when the segment is
// visible, and last a hand-over step; the result is valid the cycle after
// the hand-over. in_ch is not ready while a line is being worked on.
// The result waits in an output register, so the next command is taken
// while out_ch stalls; a second line then holds at its last step until the
// register is free.
// Reset clears the stored point to the origin, the registers to their
// defaults and drops any item in flight.
module polyline_clip_and_scale_top
  import pcs_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int SCREEN_BITS     = DEF_SCREEN_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  pcs_in_if.sink     in_ch,
  pcs_out_if.source  out_ch,
  pcs_cfg_if.sink    cfg_ch
);

  localparam int W  = 34;
  localparam int PW = 51;
  localparam int AW = 65;
  localparam int RW = 53;
  localparam int SB = SCREEN_BITS;
  localparam logic signed [W-1:0] ONE = W'(64'd1 << COORD_FRAC_BITS);
  localparam longint TOL_L = ((longint'(101) << COORD_FRAC_BITS) + 50) / 100;
  localparam logic [W-1:0] TOL = W'(TOL_L);
  localparam logic signed [RW-1:0] SMAX = RW'((64'd1 << (SB - 1)) - 1);
  localparam logic signed [RW-1:0] SMIN = -RW'(64'd1 << (SB - 1));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CROSS = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CPT   = 3'd5;
  localparam logic [2:0] S_MAP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic is_in(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    return (mag(x) < TOL) && (mag(y) < TOL);
  endfunction

  logic [2:0]               state_r, state_nxt;
  logic [SCALE_W-1:0]       scale_r;
  logic [OFFS_W-1:0]        left_r, top_r;
  logic signed [COORD_W-1:0] last_x_r, last_y_r;
  logic signed [W-1:0]      p_x_r, p_y_r, l_x_r, l_y_r, dx_r, dy_r;
  logic signed [W-1:0]      px_r [2];
  logic signed [W-1:0]      py_r [2];
  logic [1:0]               cnt_r;
  logic [1:0]               i_r;
  logic [4:0]               k_r;
  logic [2:0]               j_r;
  logic [W-1:0]             rem_r, div_r;
  logic [30:0]              q_r;
  logic [PW-1:0]            mul_p_r;
  logic [AW-1:0]            acc_x_r, acc_y_r;
  logic signed [SB-1:0]     res_r [4];
  logic                     out_valid_r, out_vis_r;
  logic signed [SB-1:0]     out_res_r [4];

  // Shared multiplier operands.
  logic [W-1:0]  mul_a;
  logic [16:0]   mul_b;

  // Crossing numerator and denominator for the boundary in turn.
  logic signed [W-1:0] num, den;
  logic                cross_ok;

  // Restoring divider step.
  logic [W:0]    rem_sh;
  logic          rem_ge;

  // Crossing point and mapping.
  logic signed [W-1:0] cx, cy, nmap, nis;
  logic [1:0]          kmap;
  logic [PW-1:0]       msh;
  logic signed [RW-1:0] rmap;
  logic [OFFS_W-1:0]   offs;
  logic signed [SB-1:0] smap;
  logic                in_acc, line_acc;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign line_acc = in_acc && (in_ch.func == FUNC_LINE);
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Boundary selection: x=+1, x=-1, y=+1, y=-1.
  always_comb begin
    unique case (i_r)
      2'd0: begin num = ONE - p_x_r;  den = dx_r; end
      2'd1: begin num = -ONE - p_x_r; den = dx_r; end
      2'd2: begin num = ONE - p_y_r;  den = dy_r; end
      default: begin num = -ONE - p_y_r; den = dy_r; end
    endcase
    cross_ok = (num != '0) && (den != '0) && (num[W-1] == den[W-1]) && (mag(num) < mag(den));
  end

  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, div_r};

  // Crossing point from the scaled products.
  assign cx = dx_r[W-1] ? p_x_r - W'(acc_x_r[AW-1:31]) : p_x_r + W'(acc_x_r[AW-1:31]);
  assign cy = dy_r[W-1] ? p_y_r - W'(acc_y_r[AW-1:31]) : p_y_r + W'(acc_y_r[AW-1:31]);

  // Screen value for mapping step kmap (issued at j, consumed at j+1).
  always_comb begin
    kmap = (state_r == S_MAP && j_r != 3'd0) ? 2'(j_r - 3'd1) : j_r[1:0];
    unique case (kmap)
      2'd0: nmap = px_r[0] + ONE;
      2'd1: nmap = ONE - py_r[0];
      2'd2: nmap = px_r[1] + ONE;
      default: nmap = ONE - py_r[1];
    endcase
    // The value sent into the multiplier in this step.
    unique case (j_r[1:0])
      2'd0: nis = px_r[0] + ONE;
      2'd1: nis = ONE - py_r[0];
      2'd2: nis = px_r[1] + ONE;
      default: nis = ONE - py_r[1];
    endcase
    offs = kmap[0] ? top_r : left_r;
    msh  = mul_p_r >> (COORD_FRAC_BITS + 4);
    rmap = (nmap[W-1] ? -RW'(msh) : RW'(msh)) + RW'(offs);
    if (rmap > SMAX) begin
      smap = SMAX[SB-1:0];
    end else if (rmap < SMIN) begin
      smap = SMIN[SB-1:0];
    end else begin
      smap = rmap[SB-1:0];
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_MUL) begin
      mul_a = j_r[1] ? mag(dy_r) : mag(dx_r);
      mul_b = j_r[0] ? 17'(q_r[30:16]) : 17'(q_r[15:0]);
    end else if (state_r == S_MAP) begin
      mul_a = mag(nis);
      mul_b = 17'(scale_r);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (line_acc) state_nxt = S_CHECK;
      S_CHECK: begin
        if (is_in(p_x_r, p_y_r) && is_in(l_x_r, l_y_r)) state_nxt = S_MAP;
        else state_nxt = S_CROSS;
      end
      S_CROSS: begin
        if (cross_ok) state_nxt = S_DIV;
        else if (i_r == 2'd3) state_nxt = S_DONE;
      end
      S_DIV:   if (k_r == 5'd30) state_nxt = S_MUL;
      S_MUL:   if (j_r == 3'd4) state_nxt = S_CPT;
      S_CPT: begin
        if (is_in(cx, cy) && cnt_r == 2'd1) state_nxt = S_MAP;
        else if (i_r == 2'd3) state_nxt = S_DONE;
        else state_nxt = S_CROSS;
      end
      S_MAP:   if (j_r == 3'd4) state_nxt = S_DONE;
      default: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      scale_r     <= SCALE_RST;
      left_r      <= '0;
      top_r       <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_SCALE: scale_r <= cfg_ch.data[SCALE_W-1:0];
          REG_LEFT:  left_r  <= cfg_ch.data[OFFS_W-1:0];
          REG_TOP:   top_r   <= cfg_ch.data[OFFS_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        last_x_r <= in_ch.pos_x;
        last_y_r <= in_ch.pos_y;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    mul_p_r <= PW'(mul_a) * PW'(mul_b);
    unique case (state_r)
      S_IDLE: begin
        p_x_r <= W'(in_ch.pos_x);
        p_y_r <= W'(in_ch.pos_y);
        l_x_r <= W'(last_x_r);
        l_y_r <= W'(last_y_r);
        dx_r  <= W'(last_x_r) - W'(in_ch.pos_x);
        dy_r  <= W'(last_y_r) - W'(in_ch.pos_y);
      end
      S_CHECK: begin
        i_r <= 2'd0;
        if (is_in(p_x_r, p_y_r)) begin
          px_r[0] <= p_x_r;
          py_r[0] <= p_y_r;
          if (is_in(l_x_r, l_y_r)) begin
            px_r[1] <= l_x_r;
            py_r[1] <= l_y_r;
            cnt_r   <= 2'd2;
          end else begin
            cnt_r <= 2'd1;
          end
        end else if (is_in(l_x_r, l_y_r)) begin
          px_r[0] <= l_x_r;
          py_r[0] <= l_y_r;
          cnt_r   <= 2'd1;
        end else begin
          cnt_r <= 2'd0;
        end
        j_r <= 3'd0;
      end
      S_CROSS: begin
        rem_r <= mag(num);
        div_r <= mag(den);
        k_r   <= 5'd0;
        j_r   <= 3'd0;
        if (!cross_ok) i_r <= i_r + 2'd1;
      end
      S_DIV: begin
        q_r   <= {q_r[29:0], rem_ge};
        rem_r <= rem_ge ? W'(rem_sh - {1'b0, div_r}) : W'(rem_sh);
        k_r   <= k_r + 5'd1;
      end
      S_MUL: begin
        j_r <= j_r + 3'd1;
        unique case (j_r)
          3'd1: acc_x_r <= AW'(mul_p_r);
          3'd2: acc_x_r <= acc_x_r + (AW'(mul_p_r) << 16);
          3'd3: acc_y_r <= AW'(mul_p_r);
          3'd4: acc_y_r <= acc_y_r + (AW'(mul_p_r) << 16);
          default: ;
        endcase
      end
      S_CPT: begin
        i_r <= i_r + 2'd1;
        j_r <= 3'd0;
        if (is_in(cx, cy)) begin
          px_r[cnt_r[0]] <= cx;
          py_r[cnt_r[0]] <= cy;
          cnt_r          <= cnt_r + 2'd1;
        end
      end
      S_MAP: begin
        j_r <= j_r + 3'd1;
        if (j_r != 3'd0) res_r[kmap] <= smap;
      end
      default: begin
        if (!out_valid_r || out_ch.ready) begin
          out_vis_r <= (cnt_r == 2'd2);
          for (int n = 0; n < 4; n++) begin
            out_res_r[n] <= (cnt_r == 2'd2) ? res_r[n] : '0;
          end
        end
      end
    endcase
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.visible = out_vis_r;
  assign out_ch.x_start = out_res_r[0];
  assign out_ch.y_start = out_res_r[1];
  assign out_ch.x_end   = out_res_r[2];
  assign out_ch.y_end   = out_res_r[3];

  // The divider remainder always stays below the divisor.
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // No more than two points are ever gathered.
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CPT) |-> (cnt_r != 2'd2 && cnt_r != 2'd3))
    else $error("point count overflow");

  // An invisible result carries zero coordinates.
  a_invis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vis_r) |-> (out_res_r[0] == '0 && out_res_r[3] == '0))
    else $error("invisible result with coordinates");

  // A line accepted in idle always starts the check step.
  a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    line_acc |=> (state_r == S_CHECK))
    else $error("line command not started");

endmodule
